// ----- src/lsrc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrc_pkg
// Shared constants, codes and interface structs of the Lagrange sample rate
// converter.
// ----------------------------------------------------------------------------
package lsrc_pkg;

    // Buffer sizing
    localparam int MAX_SAMPLES = 65536;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

    // Sample and position formats
    localparam int SAMPLE_W = 16;
    localparam int FRAC_W   = 16;
    localparam int RATE_W   = 24;
    localparam int POS_W    = ((CNT_W + FRAC_W > RATE_W) ? CNT_W + FRAC_W : RATE_W) + 1;
    localparam int S_W      = POS_W - FRAC_W;

    // Q16 unity and reciprocal of six for the cubic weights
    localparam int ONE_Q16     = 65536;
    localparam int RECIP_6     = 349526;
    localparam int RECIP_SHIFT = 21;

    // Configuration port
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_RATE_STEP  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_DROP_FINAL = 1'b1;

    localparam logic [RATE_W-1:0] RATE_STEP_RESET = 24'd65536;

    // Request action codes
    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_FETCH  = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    // Read lanes: neighbors s-1, s, s+1, s+2
    localparam logic [1:0] LANE_PREV  = 2'd0;
    localparam logic [1:0] LANE_CUR   = 2'd1;
    localparam logic [1:0] LANE_NEXT  = 2'd2;
    localparam logic [1:0] LANE_NEXT2 = 2'd3;

    typedef struct packed {
        logic [RATE_W-1:0] rate_step;
        logic              drop_final;
    } cfg_t;

    typedef struct packed {
        logic       append;
        logic       clear;
        logic       rd_en;
        logic [1:0] rd_lane;
        logic       finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic has_out;
        logic out_free;
    } dp_status_t;

endpackage

// ----- src/lsrc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrc_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module lsrc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/lsrc_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrc_regs
// APB configuration registers: rate step and drop-final flag.
// ----------------------------------------------------------------------------
module lsrc_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lsrc_pkg::PADDR_W-1:0]   paddr,
    input  logic [lsrc_pkg::PDATA_W-1:0]   pwdata,
    output logic [lsrc_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output lsrc_pkg::cfg_t                 cfg
);

    logic [lsrc_pkg::RATE_W-1:0]    rate_step_reg;
    logic                           drop_final_reg;
    logic [lsrc_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[lsrc_pkg::PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    // Write on the access phase of a write request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_step_reg  <= lsrc_pkg::RATE_STEP_RESET;
            drop_final_reg <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                lsrc_pkg::REG_RATE_STEP:  rate_step_reg  <= pwdata[lsrc_pkg::RATE_W-1:0];
                lsrc_pkg::REG_DROP_FINAL: drop_final_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            lsrc_pkg::REG_RATE_STEP:
                prdata = lsrc_pkg::PDATA_W'(rate_step_reg);
            lsrc_pkg::REG_DROP_FINAL:
                prdata = lsrc_pkg::PDATA_W'(drop_final_reg);
            default:
                prdata = '0;
        endcase
    end

    assign cfg.rate_step  = rate_step_reg;
    assign cfg.drop_final = drop_final_reg;

endmodule

// ----- src/lsrc_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrc_dp
// Datapath: sample store, length and position, Lagrange weight pipeline,
// four-lane multiply-accumulate and the output register.
// ----------------------------------------------------------------------------
module lsrc_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  lsrc_pkg::ctrl_cmd_t                   cmd,
    output lsrc_pkg::dp_status_t                  status,
    input  lsrc_pkg::cfg_t                        cfg,
    input  logic signed [lsrc_pkg::SAMPLE_W-1:0]  sample_in,
    input  logic                                  m_ready,
    output logic                                  m_valid,
    output logic signed [lsrc_pkg::SAMPLE_W-1:0]  m_sample_out,
    output logic                                  m_is_last,
    output logic                                  m_exhausted
);

    localparam int POS_W  = lsrc_pkg::POS_W;
    localparam int S_W    = lsrc_pkg::S_W;
    localparam int CNT_W  = lsrc_pkg::CNT_W;
    localparam int FRAC_W = lsrc_pkg::FRAC_W;
    localparam int ADDR_W = lsrc_pkg::ADDR_W;

    // Length and position
    logic [CNT_W-1:0]  count_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [S_W-1:0]    s_idx;
    logic [FRAC_W-1:0] frac;
    logic [POS_W-1:0]  end_pos;
    logic [POS_W:0]    pos_step;
    logic [POS_W:0]    np_reg;
    logic [POS_W+1:0]  np_step;
    logic              has_out;
    logic              has_next;
    logic              has_next_reg;
    logic              cubic;
    logic              next_in_range;
    logic [S_W:0]      s_ext;
    logic [S_W:0]      cnt_ext;

    // Sample store
    logic                        wr_en;
    logic [S_W-1:0]              lane_addr;
    logic [lsrc_pkg::SAMPLE_W-1:0] ram_q;
    logic                        cap_en_reg;
    logic [1:0]                  cap_lane_reg;
    logic signed [15:0]          d_reg [4];

    // Weight pipeline
    logic [15:0]        op_a;
    logic [16:0]        op_b;
    logic [17:0]        op_c;
    logic [16:0]        op_e;
    logic [32:0]        ab_reg;
    logic [34:0]        bc_reg;
    logic [32:0]        ea_reg;
    logic [50:0]        abc_reg;
    logic [49:0]        eab_reg;
    logic [51:0]        ebc_reg;
    logic [50:0]        eac_reg;
    logic [37:0]        q0_reg;
    logic [37:0]        q3_reg;
    logic [18:0]        w1_reg;
    logic [17:0]        w2_reg;
    logic signed [17:0] coef_next [4];
    logic signed [17:0] coef_reg  [4];

    // Accumulate and result
    logic signed [33:0] prod_reg [4];
    logic signed [35:0] acc_reg;
    logic signed [35:0] acc_adj;
    logic signed [19:0] quot;
    logic signed [15:0] sat;

    // Output register
    logic               out_valid_reg;
    logic signed [15:0] out_sample_reg;
    logic               out_last_reg;
    logic               out_exh_reg;

    assign s_idx   = pos_reg[POS_W-1:FRAC_W];
    assign frac    = pos_reg[FRAC_W-1:0];
    assign end_pos = {{(POS_W-CNT_W-FRAC_W){1'b0}}, count_reg, {FRAC_W{1'b0}}};
    assign s_ext   = {1'b0, s_idx};
    assign cnt_ext = (S_W+1)'(count_reg);

    // Output remains for the current and the following position
    assign pos_step = {1'b0, pos_reg} + (POS_W+1)'(cfg.rate_step);
    assign has_out  = (pos_reg < end_pos)
                   && !(cfg.drop_final && (pos_step >= {1'b0, end_pos}));
    assign np_step  = {1'b0, np_reg} + (POS_W+2)'(cfg.rate_step);
    assign has_next = (np_reg < {1'b0, end_pos})
                   && !(cfg.drop_final && (np_step >= {2'b0, end_pos}));

    // Cubic only with two neighbors on each side
    assign cubic         = (s_idx >= S_W'(2)) && ((s_ext + (S_W+1)'(2)) < cnt_ext);
    assign next_in_range = (s_ext + (S_W+1)'(1)) < cnt_ext;

    always_ff @(posedge aclk) begin
        np_reg       <= pos_step;
        has_next_reg <= has_next;
    end

    // Store address for each lane; the linear case reads s and clamped s+1
    always_comb begin
        case (cmd.rd_lane)
            lsrc_pkg::LANE_PREV:  lane_addr = cubic ? s_idx - S_W'(1) : s_idx;
            lsrc_pkg::LANE_CUR:   lane_addr = s_idx;
            lsrc_pkg::LANE_NEXT:  lane_addr = (cubic || next_in_range) ? s_idx + S_W'(1)
                                                                      : s_idx;
            lsrc_pkg::LANE_NEXT2: lane_addr = cubic ? s_idx + S_W'(2) : s_idx;
            default:              lane_addr = s_idx;
        endcase
    end

    assign wr_en = cmd.append && (count_reg < CNT_W'(lsrc_pkg::MAX_SAMPLES));

    lsrc_ram #(
        .WIDTH (lsrc_pkg::SAMPLE_W),
        .DEPTH (lsrc_pkg::MAX_SAMPLES)
    ) u_ram (
        .clk   (aclk),
        .we    (wr_en),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (sample_in),
        .re    (cmd.rd_en),
        .raddr (lane_addr[ADDR_W-1:0]),
        .rdata (ram_q)
    );

    // Track which lane the read data belongs to
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_en_reg <= 1'b0;
        end else begin
            cap_en_reg <= cmd.rd_en;
        end
        cap_lane_reg <= cmd.rd_lane;
        if (cap_en_reg) begin
            d_reg[cap_lane_reg] <= $signed(ram_q);
        end
    end

    // Lagrange factors at 1+f: a=f, b=1-f, c=2-f, e=1+f (magnitudes)
    assign op_a = frac;
    assign op_b = 17'(lsrc_pkg::ONE_Q16) - {1'b0, frac};
    assign op_c = 18'(2 * lsrc_pkg::ONE_Q16) - {2'b0, frac};
    assign op_e = 17'(lsrc_pkg::ONE_Q16) + {1'b0, frac};

    // Pairwise products, triple products, then scale by 1/2 or 1/6
    always_ff @(posedge aclk) begin
        ab_reg  <= 33'(op_a) * 33'(op_b);
        bc_reg  <= 35'(op_b) * 35'(op_c);
        ea_reg  <= 33'(op_e) * 33'(op_a);
        abc_reg <= 51'(ab_reg) * 51'(op_c);
        eab_reg <= 50'(ab_reg) * 50'(op_e);
        ebc_reg <= 52'(bc_reg) * 52'(op_e);
        eac_reg <= 51'(ea_reg) * 51'(op_c);
        q0_reg  <= 38'(abc_reg[50:32]) * 38'(lsrc_pkg::RECIP_6);
        q3_reg  <= 38'(eab_reg[49:32]) * 38'(lsrc_pkg::RECIP_6);
        w1_reg  <= ebc_reg[51:33];
        w2_reg  <= eac_reg[50:33];
        coef_reg <= coef_next;
    end

    // Pick cubic weights or the two linear weights
    always_comb begin
        if (cubic) begin
            coef_next[0] = -$signed({1'b0, q0_reg[lsrc_pkg::RECIP_SHIFT +: 17]});
            coef_next[1] = $signed({1'b0, w1_reg[16:0]});
            coef_next[2] = $signed({1'b0, w2_reg[16:0]});
            coef_next[3] = -$signed({1'b0, q3_reg[lsrc_pkg::RECIP_SHIFT +: 17]});
        end else begin
            coef_next[0] = '0;
            coef_next[1] = $signed({1'b0, op_b});
            coef_next[2] = $signed({2'b0, frac});
            coef_next[3] = '0;
        end
    end

    // Multiply each lane, then sum
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 4; i++) begin
            prod_reg[i] <= 34'(coef_reg[i]) * 34'(d_reg[i]);
        end
        acc_reg <= 36'(prod_reg[0]) + 36'(prod_reg[1])
                 + 36'(prod_reg[2]) + 36'(prod_reg[3]);
    end

    // Truncate toward zero and saturate
    assign acc_adj = acc_reg[35] ? acc_reg + 36'sd65535 : acc_reg;
    assign quot    = acc_adj[35:16];
    always_comb begin
        if (quot > 20'sd32767) begin
            sat = 16'sh7fff;
        end else if (quot < -20'sd32768) begin
            sat = -16'sh8000;
        end else begin
            sat = quot[15:0];
        end
    end

    // Length, position and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear) begin
                count_reg <= '0;
                pos_reg   <= '0;
            end else if (wr_en) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (cmd.finish && has_out) begin
                pos_reg <= np_reg[POS_W-1:0];
            end
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (cmd.finish) begin
            out_sample_reg <= has_out ? sat : '0;
            out_last_reg   <= has_out && !has_next_reg;
            out_exh_reg    <= !has_out;
        end
    end

    assign status.has_out  = has_out;
    assign status.out_free = !out_valid_reg || m_ready;

    assign m_valid      = out_valid_reg;
    assign m_sample_out = out_sample_reg;
    assign m_is_last    = out_last_reg;
    assign m_exhausted  = out_exh_reg;

endmodule

// ----- src/lsrc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrc_ctrl
// Controller: takes requests, sequences the four store reads of a fetch and
// hands the finished result to the output register.
// ----------------------------------------------------------------------------
module lsrc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_action,
    input  lsrc_pkg::dp_status_t status,
    output lsrc_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_CAP,
        ST_MUL,
        ST_SUM,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   accept;

    assign accept  = s_valid && ready_reg;
    assign s_ready = ready_reg;

    // Hold state and the ready flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

    // Next state and commands
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.rd_lane = lsrc_pkg::LANE_PREV;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_action)
                        lsrc_pkg::ACT_APPEND: cmd.append = 1'b1;
                        lsrc_pkg::ACT_CLEAR:  cmd.clear  = 1'b1;
                        lsrc_pkg::ACT_FETCH:  state_next = ST_CHECK;
                        default: ;
                    endcase
                end
            end
            ST_CHECK: begin
                // Skip the reads when nothing is left
                cmd.rd_en   = status.has_out;
                cmd.rd_lane = lsrc_pkg::LANE_PREV;
                state_next  = status.has_out ? ST_RD1 : ST_DONE;
            end
            ST_RD1: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_lane = lsrc_pkg::LANE_CUR;
                state_next  = ST_RD2;
            end
            ST_RD2: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_lane = lsrc_pkg::LANE_NEXT;
                state_next  = ST_RD3;
            end
            ST_RD3: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_lane = lsrc_pkg::LANE_NEXT2;
                state_next  = ST_CAP;
            end
            ST_CAP: state_next = ST_MUL;
            ST_MUL: state_next = ST_SUM;
            ST_SUM: state_next = ST_DONE;
            ST_DONE: begin
                // Wait for room in the output register
                cmd.finish = status.out_free;
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- src/lagrange_sample_rate_converter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lagrange_sample_rate_converter_top
// Sample buffer with a cubic Lagrange / linear resampling read-out.
//
//   Channel  Direction  Handshake            Payload
//   s_       in         s_valid / s_ready    s_action, s_sample_in
//   m_       out        m_valid / m_ready    m_sample_out, m_is_last, m_exhausted
//   APB      in         psel/penable/pready  paddr, pwdata, prdata
//
// Append, clear and unknown requests leave the block ready again in the next cycle.
// A fetch runs the four reads of the single store read port, then the lane
// multiply and the sum; an exhausted fetch skips the reads and arithmetic.
// Requests are taken while a result waits; a fetch holds in its last
// cycle until the output register is free.
// Reset clears length, position and handshake state; the store is not cleared.
// ----------------------------------------------------------------------------
module lagrange_sample_rate_converter_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [1:0]                            s_action,
    input  logic signed [lsrc_pkg::SAMPLE_W-1:0]  s_sample_in,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [lsrc_pkg::SAMPLE_W-1:0]  m_sample_out,
    output logic                                  m_is_last,
    output logic                                  m_exhausted,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [lsrc_pkg::PADDR_W-1:0]          paddr,
    input  logic [lsrc_pkg::PDATA_W-1:0]          pwdata,
    output logic [lsrc_pkg::PDATA_W-1:0]          prdata,
    output logic                                  pready
);

    lsrc_pkg::cfg_t       cfg;
    lsrc_pkg::ctrl_cmd_t  cmd;
    lsrc_pkg::dp_status_t status;

    lsrc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lsrc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .status   (status),
        .cmd      (cmd)
    );

    lsrc_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .cfg          (cfg),
        .sample_in    (s_sample_in),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_sample_out (m_sample_out),
        .m_is_last    (m_is_last),
        .m_exhausted  (m_exhausted)
    );

endmodule

// ----- src/lsrc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrc_props
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module lsrc_props (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic [1:0]                            s_action,
    input logic signed [lsrc_pkg::SAMPLE_W-1:0]  s_sample_in,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic signed [lsrc_pkg::SAMPLE_W-1:0]  m_sample_out,
    input logic                                  m_is_last,
    input logic                                  m_exhausted,
    input logic                                  psel,
    input logic                                  penable,
    input logic                                  pwrite,
    input logic [lsrc_pkg::PADDR_W-1:0]          paddr,
    input logic [lsrc_pkg::PDATA_W-1:0]          pwdata,
    input logic [lsrc_pkg::PDATA_W-1:0]          prdata,
    input logic                                  pready
);

    // A fetch occupies the block for the following cycle
    a_fetch_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_action == lsrc_pkg::ACT_FETCH) |=> !s_ready)
        else $error("ready stayed high after a fetch request");

    // Other requests leave the block ready in the following cycle
    a_other_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_action != lsrc_pkg::ACT_FETCH) |=> s_ready)
        else $error("ready dropped after a non-fetch request");

    // An exhausted result carries a zero sample and no last flag
    a_exhausted_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_exhausted |-> (m_sample_out == 16'sd0) && !m_is_last)
        else $error("exhausted result with nonzero payload");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample_out)
                                && $stable(m_is_last) && $stable(m_exhausted))
        else $error("stalled result changed");

endmodule

bind lagrange_sample_rate_converter_top lsrc_props u_lsrc_props (.*);
